@@ sv/pidaw_pkg.sv @@
package pidaw_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegGainP         = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI         = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD         = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegralLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutputLimit   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWrapEnable    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWrapSpan      = 3'd6;

  localparam logic [15:0] WrapSpanReset = 16'd8192;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } out_item_t;

endpackage

@@ sv/pid_with_angle_wrap_unit.sv @@
// throughput: one item per cycle while out_stall_i is low, set by the
// five-register pipeline (input, error, products, integral, result); the
// integral and previous error state close their loops within a single stage each
// reset: gains, limits, wrap enable, integral and previous error clear to zero,
// the wrap span to 8192; all pipeline valids clear
module pid_with_angle_wrap_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pidaw_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pidaw_pkg::out_item_t                out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidaw_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pidaw_pkg::CfgDataW-1:0]      cfg_data_i
);

  // configuration
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic [30:0]        ilim_q, olim_q;
  logic               wrap_en_q;
  logic [15:0]        wrap_span_q;

  // pipeline valids and handshake
  logic v0_q, v1_q, v2_q, v3_q, out_valid_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // stage payloads and state
  pidaw_pkg::in_item_t in_q;
  logic signed [17:0]  err_d, err_q, prev_err_q;
  logic signed [18:0]  derr_d, derr_q;
  logic signed [49:0]  p_d, p_q, ip_d, ip_q;
  logic signed [50:0]  dt_d, dt_q;
  logic signed [51:0]  pd_d, pd_q;
  logic signed [31:0]  int_d, int_q;
  pidaw_pkg::out_item_t out_d, out_q;

  // error and fold
  logic signed [18:0] raw_err, two_err, span_s;
  logic signed [18:0] fold_err;
  // integral and drive clamps
  logic signed [50:0] isum, ilim_s;
  logic signed [52:0] dsum, olim_s;

  assign cfg_ready_o = 1'b1;

  assign rdy4 = !out_valid_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  always_comb begin
    raw_err = 19'(in_q.target) - 19'(in_q.measured);
    two_err = raw_err <<< 1;
    span_s  = $signed({3'b000, wrap_span_q});
    fold_err = raw_err;
    if (wrap_en_q) begin
      if (two_err > span_s) begin
        fold_err = raw_err - span_s;
      end else if (two_err < -span_s) begin
        fold_err = raw_err + span_s;
      end
    end
    err_d  = fold_err[17:0];
    derr_d = 19'(err_d) - 19'(prev_err_q);
  end

  always_comb begin
    p_d  = 50'(gain_p_q) * 50'(err_q);
    ip_d = 50'(gain_i_q) * 50'(err_q);
    dt_d = 51'(gain_d_q) * 51'(derr_q);
  end

  always_comb begin
    isum   = 51'(int_q) + 51'(ip_q);
    ilim_s = $signed({20'd0, ilim_q});
    if (isum > ilim_s) begin
      int_d = ilim_s[31:0];
    end else if (isum < -ilim_s) begin
      int_d = -ilim_s[31:0];
    end else begin
      int_d = isum[31:0];
    end
    pd_d = 52'(p_q) + 52'(dt_q);
  end

  // int_q holds the integral of the item in the integral stage
  always_comb begin
    dsum   = 53'(pd_q) + 53'(int_q);
    olim_s = $signed({22'd0, olim_q});
    if (dsum > olim_s) begin
      out_d.drive   = olim_s[31:0];
      out_d.clamped = 1'b1;
    end else if (dsum < -olim_s) begin
      out_d.drive   = -olim_s[31:0];
      out_d.clamped = 1'b1;
    end else begin
      out_d.drive   = dsum[31:0];
      out_d.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      ilim_q      <= '0;
      olim_q      <= '0;
      wrap_en_q   <= 1'b0;
      wrap_span_q <= pidaw_pkg::WrapSpanReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pidaw_pkg::RegGainP:         gain_p_q    <= $signed(cfg_data_i);
        pidaw_pkg::RegGainI:         gain_i_q    <= $signed(cfg_data_i);
        pidaw_pkg::RegGainD:         gain_d_q    <= $signed(cfg_data_i);
        pidaw_pkg::RegIntegralLimit: ilim_q      <= cfg_data_i[30:0];
        pidaw_pkg::RegOutputLimit:   olim_q      <= cfg_data_i[30:0];
        pidaw_pkg::RegWrapEnable:    wrap_en_q   <= cfg_data_i[0];
        pidaw_pkg::RegWrapSpan:      wrap_span_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      prev_err_q  <= '0;
      int_q       <= '0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) out_valid_q <= v3_q;
      if (v0_q && rdy1) prev_err_q <= err_d;
      if (v2_q && rdy3) int_q <= int_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy0) begin
      in_q <= in_item_i;
    end
    if (v0_q && rdy1) begin
      err_q  <= err_d;
      derr_q <= derr_d;
    end
    if (v1_q && rdy2) begin
      p_q  <= p_d;
      ip_q <= ip_d;
      dt_q <= dt_d;
    end
    if (v2_q && rdy3) begin
      pd_q <= pd_d;
    end
    if (v3_q && rdy4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // an empty result register never holds back the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // an empty input stage always takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> !in_stall_o)
    else $error("input stalled with empty input stage");

  // a freshly loaded drive lies within the limit in force at load time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(v3_q && rdy4) |->
      (out_q.drive <= $signed({1'b0, $past(olim_q)}) &&
       out_q.drive >= -$signed({1'b0, $past(olim_q)})))
    else $error("drive outside output limit");

  // a clamped result sits exactly on the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(v3_q && rdy4) && out_q.clamped |->
      (out_q.drive == $signed({1'b0, $past(olim_q)}) ||
       out_q.drive == -$signed({1'b0, $past(olim_q)})))
    else $error("clamped drive not on the limit");

endmodule
